[hw/rtl/salc_pkg.sv]
// shared constants, types and struct for the lru cache update block
package salc_pkg;

  localparam int WAYS              = 4;
  localparam int SETS              = 16;
  localparam int BLOCK_OFFSET_BITS = 4;
  localparam int ADDRESS_BITS      = 32;

  // address split, sets a power of two so set and tag are bit fields
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int SET_FIELD_W = (SETS > 1) ? $clog2(SETS) : 0;
  localparam int TAG_W = ADDRESS_BITS - BLOCK_OFFSET_BITS - SET_FIELD_W;
  localparam int AGE_W = $clog2(WAYS);

  // widths of the result fields on the ports
  localparam int ADDR_PORT_W   = 32;
  localparam int HIT_AGE_W     = 2;
  localparam int SET_INDEX_W   = 4;
  localparam int EVICTED_TAG_W = 24;

  typedef logic [TAG_W-1:0]            tag_t;
  typedef logic [WAYS-1:0][TAG_W-1:0]  row_t;
  typedef logic [WAYS-1:0]             vrow_t;
  typedef logic [SET_W-1:0]            set_t;
  typedef logic [AGE_W-1:0]            age_t;

  // outcome of one row update
  typedef struct packed {
    logic  hit;
    age_t  age;
    logic  evicted;
    tag_t  ev_tag;
    row_t  tags;
    vrow_t valid;
  } upd_t;

endpackage

[hw/rtl/salc_tag_ram.sv]
// tag memory, one row of all ways per set, registered read
module salc_tag_ram
  import salc_pkg::*;
(
  input  logic clk,
  input  logic wr_en,
  input  set_t wr_addr,
  input  row_t wr_data,
  input  logic rd_en,
  input  set_t rd_addr,
  output row_t rd_data
);

  row_t mem [SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hw/rtl/salc_row_update.sv]
// tag compare across the ways and age shift of one set row
module salc_row_update
  import salc_pkg::*;
(
  input  tag_t  tag,
  input  row_t  old_tags,
  input  vrow_t old_valid,
  output upd_t  upd
);

  logic [WAYS-1:0] match;
  logic            found;
  age_t            found_age;
  age_t            pos;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = old_valid[i] && (old_tags[i] == tag);
    end
  end

  // youngest matching age wins
  always_comb begin
    found     = 1'b0;
    found_age = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found     = 1'b1;
        found_age = AGE_W'(i);
      end
    end
  end

  assign pos = found ? found_age : AGE_W'(WAYS - 1);

  always_comb begin
    upd.hit     = found;
    upd.age     = found ? found_age : '0;
    upd.evicted = !found && old_valid[WAYS-1];
    upd.ev_tag  = upd.evicted ? old_tags[WAYS-1] : '0;
    upd.tags[0]  = tag;
    upd.valid[0] = 1'b1;
    for (int i = 1; i < WAYS; i++) begin
      if (AGE_W'(i) <= pos) begin
        upd.tags[i]  = old_tags[i-1];
        upd.valid[i] = old_valid[i-1];
      end else begin
        upd.tags[i]  = old_tags[i];
        upd.valid[i] = old_valid[i];
      end
    end
  end

endmodule

[hw/rtl/set_assoc_lru_cache_update.sv]
// top level of the set associative true-lru cache update block
//
//   channel  | handshake     | payload
//   ---------+---------------+--------------------------------------------
//   access   | start / busy  | address
//   result   | done (strobe) | hit, hit_age, set_index, evicted, evicted_tag
//
// an access transfer: the set row is read from the tag memory in the accept
// cycle, compared, shifted and written back in the next one, so the next
// access can be taken in the cycle the result is shown
// busy is high for the single lookup cycle; the memory read latency sets this
// rst (synchronous) clears the valid bits of every entry at once and the
// control state; the tag memory itself is never cleared
// done is high for exactly one cycle per access; the receiver cannot stall
module set_assoc_lru_cache_update
  import salc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [ADDR_PORT_W-1:0]   address,
  output logic                     done,
  output logic                     hit,
  output logic [HIT_AGE_W-1:0]     hit_age,
  output logic [SET_INDEX_W-1:0]   set_index,
  output logic                     evicted,
  output logic [EVICTED_TAG_W-1:0] evicted_tag
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_LOOKUP = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic  accept;
  set_t  in_set;
  tag_t  in_tag;

  // access held across the lookup cycle
  set_t  set_q;
  tag_t  tag_q;

  row_t  rd_row;
  upd_t  upd;

  // per-entry valid bits, one row per set, cleared by reset
  vrow_t valid [SETS];

  assign busy   = (state == ST_LOOKUP);
  assign accept = start && !busy;

  // plain bit-field split of the address
  assign in_set = (SETS > 1) ? set_t'(address[BLOCK_OFFSET_BITS +: SET_W]) : '0;
  assign in_tag = address[BLOCK_OFFSET_BITS + SET_FIELD_W +: TAG_W];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_LOOKUP: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      set_q <= in_set;
      tag_q <= in_tag;
    end
  end

  // read in the accept cycle, write back at the end of the lookup cycle;
  // the next read can only come after that write, so it always sees the new row
  salc_tag_ram u_tag_ram (
    .clk     (clk),
    .wr_en   (busy),
    .wr_addr (set_q),
    .wr_data (upd.tags),
    .rd_en   (accept),
    .rd_addr (in_set),
    .rd_data (rd_row)
  );

  salc_row_update u_row_update (
    .tag       (tag_q),
    .old_tags  (rd_row),
    .old_valid (valid[set_q]),
    .upd       (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SETS; s++) begin
        valid[s] <= '0;
      end
    end else if (busy) begin
      valid[set_q] <= upd.valid;
    end
  end

  // result strobe, one cycle per access
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      hit         <= upd.hit;
      hit_age     <= HIT_AGE_W'(upd.age);
      set_index   <= SET_INDEX_W'(set_q);
      evicted     <= upd.evicted;
      evicted_tag <= EVICTED_TAG_W'(upd.ev_tag);
    end
  end

endmodule

[sim/tb_top.sv]
// testbench for the set associative true-lru cache update block
`timescale 1ns / 100ps

module tb_top;
  import salc_pkg::*;

  // tracks the lru order of every set and the lookups still owed by the block
  class lru_access_tracker;
    typedef struct {
      logic                     hit;
      logic [HIT_AGE_W-1:0]     hit_age;
      logic [SET_INDEX_W-1:0]   set_index;
      logic                     evicted;
      logic [EVICTED_TAG_W-1:0] evicted_tag;
    } lookup_t;

    // age 0 is the most recently used entry of a set
    tag_t    tags  [SETS][WAYS];
    bit      valid [SETS][WAYS];
    lookup_t pending_lookups[$];
    int      mismatches;

    task report_mismatch(string what);
      if (mismatches < 30) $display("%0t mismatch: %s", $time, what);
      mismatches++;
    endtask

    function void note_access(logic [ADDR_PORT_W-1:0] a);
      logic [ADDR_PORT_W-1:0] blk;
      int      s;
      int      p;
      int      found;
      tag_t    t;
      lookup_t r;
      blk   = a >> BLOCK_OFFSET_BITS;
      s     = int'(blk % SETS);
      t     = tag_t'(blk / SETS);
      found = -1;
      for (int w = 0; w < WAYS; w++) begin
        if (found < 0 && valid[s][w] && tags[s][w] == t) found = w;
      end
      r.hit         = (found >= 0);
      r.hit_age     = (found >= 0) ? found[HIT_AGE_W-1:0] : '0;
      r.set_index   = s[SET_INDEX_W-1:0];
      r.evicted     = 1'b0;
      r.evicted_tag = '0;
      if (found < 0) begin
        p = WAYS - 1;
        // the oldest entry only leaves with a tag if it was ever filled
        if (valid[s][p]) begin
          r.evicted     = 1'b1;
          r.evicted_tag = tags[s][p];
        end
      end else begin
        p = found;
      end
      // everything younger than the touched age gets one place older
      while (p > 0) begin
        tags[s][p]  = tags[s][p-1];
        valid[s][p] = valid[s][p-1];
        p--;
      end
      tags[s][0]  = t;
      valid[s][0] = 1'b1;
      pending_lookups.push_back(r);
    endfunction

    task check_result(logic h, logic [HIT_AGE_W-1:0] age, logic [SET_INDEX_W-1:0] s,
                      logic ev, logic [EVICTED_TAG_W-1:0] ev_tag);
      lookup_t e;
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("result with no access outstanding, set %0d", s));
        return;
      end
      e = pending_lookups.pop_front();
      if (h !== e.hit)
        report_mismatch($sformatf("hit %b, expected %b", h, e.hit));
      if (age !== e.hit_age)
        report_mismatch($sformatf("hit_age %0d, expected %0d", age, e.hit_age));
      if (s !== e.set_index)
        report_mismatch($sformatf("set_index %0d, expected %0d", s, e.set_index));
      if (ev !== e.evicted)
        report_mismatch($sformatf("evicted %b, expected %b", ev, e.evicted));
      if (ev_tag !== e.evicted_tag)
        report_mismatch($sformatf("evicted_tag %h, expected %h", ev_tag, e.evicted_tag));
    endtask
  endclass

  localparam int RANDOM_ACCESSES = 650;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [ADDR_PORT_W-1:0]   address;
  logic                     done;
  logic                     hit;
  logic [HIT_AGE_W-1:0]     hit_age;
  logic [SET_INDEX_W-1:0]   set_index;
  logic                     evicted;
  logic [EVICTED_TAG_W-1:0] evicted_tag;

  lru_access_tracker tracker;

  // small tag pool, a little larger than the ways, so hits and evictions mix
  tag_t tag_pool[6];
  int   hot_set;

  set_assoc_lru_cache_update u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .address     (address),
    .done        (done),
    .hit         (hit),
    .hit_age     (hit_age),
    .set_index   (set_index),
    .evicted     (evicted),
    .evicted_tag (evicted_tag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous overall limit, well past the slowest legal run
  initial begin
    #2000000;
    $display("[set_assoc_lru_cache_update] ERROR");
    $finish;
  end

  // results cannot be held off, so every strobe is checked at the edge ending it
  always @(posedge clk) begin
    if (!rst && done) tracker.check_result(hit, hit_age, set_index, evicted, evicted_tag);
  end

  function automatic logic [ADDR_PORT_W-1:0] make_address(tag_t t, int s, int off);
    logic [ADDR_PORT_W-1:0] a;
    a = ADDR_PORT_W'(t) << (SET_FIELD_W + BLOCK_OFFSET_BITS);
    a = a | (ADDR_PORT_W'(s) << BLOCK_OFFSET_BITS) | ADDR_PORT_W'(off);
    return a;
  endfunction

  // mostly pool tags, often on the set used last, with fully random addresses as noise
  function automatic logic [ADDR_PORT_W-1:0] random_address();
    int pick;
    int s;
    pick = $urandom_range(0, 99);
    if (pick < 15) return $urandom;
    s = (pick < 55) ? hot_set : $urandom_range(0, SETS - 1);
    hot_set = s;
    return make_address(tag_pool[$urandom_range(0, 5)], s,
                        $urandom_range(0, (1 << BLOCK_OFFSET_BITS) - 1));
  endfunction

  // start stays high until the transfer; the caller decides whether it drops
  task send_access(logic [ADDR_PORT_W-1:0] a);
    start   <= 1'b1;
    address <= a;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_access(a);
  endtask

  // sender gap, address wobbles so a stray lookup would show up
  task idle_cycles(int n);
    start   <= 1'b0;
    address <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  task drain_lookups();
    start <= 1'b0;
    while (tracker.pending_lookups.size() != 0) @(posedge clk);
  endtask

  initial begin
    int   sent;
    int   burst;
    bit   paused;
    tag_t ta, tb, tc, td, te;
    tracker = new;
    rst     <= 1'b1;
    start   <= 1'b0;
    address <= '0;
    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < 6; i++) tag_pool[i] = tag_t'($urandom);
    hot_set = $urandom_range(0, SETS - 1);
    ta = tag_t'($urandom);
    tb = tag_t'($urandom);
    tc = '0;
    td = '1;
    te = tag_t'($urandom);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // address extremes into empty sets
    send_access('0);
    send_access('1);
    // fill set 3 back to back, oldest entry still empty each time
    send_access(make_address(ta, 3, 0));
    send_access(make_address(tb, 3, 5));
    send_access(make_address(tc, 3, 15));
    send_access(make_address(td, 3, 9));
    // hit at the oldest age, then at each younger age
    send_access(make_address(ta, 3, 1));
    idle_cycles(1);
    send_access(make_address(tc, 3, 2));
    send_access(make_address(ta, 3, 3));
    send_access(make_address(ta, 3, 4));
    // misses pushing valid tags out
    send_access(make_address(te, 3, 6));
    idle_cycles(2);
    send_access(make_address(tb, 3, 7));
    // same tag in another set is a separate entry
    send_access(make_address(ta, 4, 8));
    send_access('1);
    send_access(make_address(td, 15, 0));
    send_access(make_address(tc, 0, 15));
    // the sender holds off until the block has answered everything
    drain_lookups();
    @(posedge clk);

    sent   = 0;
    paused = 1'b0;
    while (sent < RANDOM_ACCESSES) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && sent < RANDOM_ACCESSES; k++) begin
        send_access(random_address());
        sent++;
      end
      if (!paused && sent >= RANDOM_ACCESSES / 2) begin
        paused = 1'b1;
        drain_lookups();
        @(posedge clk);
      end else if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 6));
      end
    end

    drain_lookups();
    repeat (4) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("[set_assoc_lru_cache_update] OK");
    end else begin
      $display("[set_assoc_lru_cache_update] ERROR");
    end
    $finish;
  end

endmodule
